### src/eos_pkg.sv
// package for the encoder output selector
// types, register indexes and reset constants used by eos_core and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package eos_pkg;

    localparam int NUM_OUTPUTS_DEF = 8;
    localparam int CFG_DATA_W      = 16;
    localparam int TIME_W          = 32;

    localparam logic [7:0]  ENC_LOCKOUT_RST = 8'd5;
    localparam logic [15:0] BTN_LOCKOUT_RST = 16'd300;

    typedef enum logic [0:0] {
        CFG_ENC_LOCKOUT = 1'b0,
        CFG_BTN_LOCKOUT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                  we;
        t_cfg_idx              index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic enc_clk_level;
        logic enc_dt_level;
        logic button_level;
    } t_tick;

    typedef struct packed {
        logic [2:0] selected_index;
        logic [7:0] output_bits;
        logic       toggled;
    } t_result;

endpackage

`default_nettype wire

### src/eos_in_if.sv
// input channel of the encoder output selector: one sampled tick per item
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface eos_in_if;
    logic valid;
    logic ready;
    logic enc_clk_level;
    logic enc_dt_level;
    logic button_level;

    modport source (output valid, output enc_clk_level, output enc_dt_level,
                    output button_level, input ready);
    modport sink (input valid, input enc_clk_level, input enc_dt_level,
                  input button_level, output ready);
endinterface

`default_nettype wire

### src/eos_out_if.sv
// result channel of the encoder output selector: selection, output bits, toggle flag
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface eos_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] selected_index;
    logic [7:0] output_bits;
    logic       toggled;

    modport source (output valid, output selected_index, output output_bits,
                    output toggled, input ready);
    modport sink (input valid, input selected_index, input output_bits,
                  input toggled, output ready);
endinterface

`default_nettype wire

### src/eos_core.sv
// selector state: lockout timers, selection, output bits, press latch, config registers
// depends on eos_pkg
`timescale 1ns / 1ps
`default_nettype none

module eos_core import eos_pkg::*; #(
    parameter int NUM_OUTPUTS = NUM_OUTPUTS_DEF
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  t_cfg_wr i_cfg,
    input  wire     i_step,
    input  t_tick   i_tick,
    output t_result o_result
);

    localparam int SEL_W = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
    localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(NUM_OUTPUTS - 1);

    logic [7:0]             r_enc_lockout;
    logic [15:0]            r_btn_lockout;
    logic [TIME_W-1:0]      r_edge_age, n_edge_age;
    logic [TIME_W-1:0]      r_tog_age, n_tog_age;
    logic                   r_prev_clk, n_prev_clk;
    logic                   r_acc_clk, n_acc_clk;
    logic [SEL_W-1:0]       r_sel, n_sel;
    logic [NUM_OUTPUTS-1:0] r_state, n_state;
    logic                   r_latched, n_latched;

    logic       edge_ok;
    logic       toggle;
    logic [63:0] sel_ext;
    logic [63:0] state_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc_lockout <= ENC_LOCKOUT_RST;
            r_btn_lockout <= BTN_LOCKOUT_RST;
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                CFG_ENC_LOCKOUT: r_enc_lockout <= i_cfg.data[7:0];
                CFG_BTN_LOCKOUT: r_btn_lockout <= i_cfg.data[15:0];
            endcase
        end
    end

    always_comb begin
        n_prev_clk = i_tick.enc_clk_level;
        n_acc_clk  = r_acc_clk;
        n_sel      = r_sel;
        n_edge_age = r_edge_age + 1'b1;
        n_tog_age  = r_tog_age + 1'b1;
        n_state    = r_state;
        n_latched  = r_latched;

        edge_ok = (i_tick.enc_clk_level != r_prev_clk)
                  && (r_edge_age >= {24'd0, r_enc_lockout});
        if (edge_ok) begin
            n_acc_clk  = i_tick.enc_clk_level;
            n_edge_age = TIME_W'(1);
            if (i_tick.enc_clk_level != r_acc_clk) begin
                if (i_tick.enc_dt_level != i_tick.enc_clk_level) begin
                    n_sel = (r_sel == SEL_LAST) ? '0 : r_sel + 1'b1;
                end else begin
                    n_sel = (r_sel == '0) ? SEL_LAST : r_sel - 1'b1;
                end
            end
        end

        // rotation first, so the toggle hits the new selection
        toggle = !i_tick.button_level && !r_latched
                 && (r_tog_age > {16'd0, r_btn_lockout});
        if (toggle) begin
            n_latched = 1'b1;
            n_tog_age = TIME_W'(1);
            n_state   = r_state ^ (NUM_OUTPUTS'(1) << n_sel);
        end
        if (i_tick.button_level) begin
            n_latched = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_age <= '0;
            r_tog_age  <= '0;
            r_prev_clk <= 1'b1;
            r_acc_clk  <= 1'b1;
            r_sel      <= '0;
            r_state    <= '0;
            r_latched  <= 1'b0;
        end else if (i_step) begin
            r_edge_age <= n_edge_age;
            r_tog_age  <= n_tog_age;
            r_prev_clk <= n_prev_clk;
            r_acc_clk  <= n_acc_clk;
            r_sel      <= n_sel;
            r_state    <= n_state;
            r_latched  <= n_latched;
        end
    end

    assign sel_ext   = 64'(n_sel);
    assign state_ext = 64'(n_state);

    assign o_result.selected_index = sel_ext[2:0];
    assign o_result.output_bits    = state_ext[7:0];
    assign o_result.toggled        = toggle;

    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_sel) < NUM_OUTPUTS)
        else $error("selection out of range");

    a_toggle_one_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && toggle) |=> ($countones(r_state ^ $past(r_state)) == 1) && r_latched)
        else $error("toggle did not flip exactly one output");

    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_tick.button_level) |=> !r_latched)
        else $error("press latch held after release");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_sel) && $stable(r_state) && $stable(r_latched))
        else $error("state changed without an item");

    a_no_toggle_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_latched && !i_tick.button_level) |=> $stable(r_state))
        else $error("output toggled while press latched");

endmodule

`default_nettype wire

### src/encoder_output_selector.sv
// encoder output selector: top level with input and result registers around the core
// depends on eos_pkg, eos_in_if, eos_out_if, eos_core
//
// usage
//   i_in carries one millisecond tick per item: encoder clock, encoder data and
//   button levels (button low means pressed). every accepted item gives exactly
//   one item on o_out: selection, low eight output bits and a toggle flag.
//   i_cfg_we with i_cfg_index 0 writes the encoder lockout (low 8 bits of
//   i_cfg_data), index 1 the button lockout (16 bits); write only while idle.
//   an accepted item waits in the input register; once the result register is
//   free or its result is being taken, the item's result is loaded into the
//   result register and o_out.valid rises. one item per cycle is sustained
//   while o_out is not stalled; the state update in the core is a pair of
//   32-bit age compares and a small selection step, all combinational.
//   a stalled o_out holds its item; the input register still takes one more
//   item, then i_in.ready drops until the result is taken.
//   reset sets selection and outputs to zero, the lockouts to 5 and 300 ticks,
//   both encoder levels to the idle high level and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module encoder_output_selector import eos_pkg::*; #(
    parameter int NUM_OUTPUTS = NUM_OUTPUTS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    eos_in_if.sink               i_in,
    eos_out_if.source            o_out,
    input  wire                  i_cfg_we,
    input  wire [0:0]            i_cfg_index,
    input  wire [CFG_DATA_W-1:0] i_cfg_data
);

    logic    r_in_valid;
    t_tick   r_tick;
    logic    r_out_valid;
    t_result r_result;
    t_result n_result;
    t_cfg_wr cfg;
    logic    advance;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = t_cfg_idx'(i_cfg_index);
    assign cfg.data  = i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_tick.enc_clk_level <= i_in.enc_clk_level;
            r_tick.enc_dt_level  <= i_in.enc_dt_level;
            r_tick.button_level  <= i_in.button_level;
        end
    end

    eos_core #(
        .NUM_OUTPUTS(NUM_OUTPUTS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (advance),
        .i_tick  (r_tick),
        .o_result(n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.selected_index = r_result.selected_index;
    assign o_out.output_bits    = r_result.output_bits;
    assign o_out.toggled        = r_result.toggled;

endmodule

`default_nettype wire
